// File: hw/rtl/gray_coord_multipass_checker_macros.svh
// Assertion macros shared by the checker RTL.
`ifndef GRAY_COORD_MULTIPASS_CHECKER_MACROS_SVH
`define GRAY_COORD_MULTIPASS_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define GCMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GCMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GCMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/gcmc_pkg.sv
package gcmc_pkg;

    localparam int MAX_SENSORS   = 4;
    localparam int CODE_W        = 8;
    localparam int CMD_W         = 2;
    localparam int PASS_W        = 2;

    localparam int SENSORS_DEF   = 4;
    localparam int PASSES_DEF    = 2;
    localparam int CODE_BITS_DEF = 8;

    localparam logic [CMD_W-1:0] CMD_X = 2'd0;
    localparam logic [CMD_W-1:0] CMD_Y = 2'd1;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_RESTART = 2'd2,
        ST_DONE    = 2'd3
    } st_t;

    typedef struct packed {
        st_t                                 status;
        logic [CMD_W-1:0]                    axis;
        logic [PASS_W-1:0]                   pass_count;
        logic                                axis_done;
        logic [MAX_SENSORS-1:0][CODE_W-1:0]  coord;
    } res_t;

endpackage

// File: hw/rtl/gcmc_gray_dec.sv
module gcmc_gray_dec #(
    parameter int CODE_BITS = gcmc_pkg::CODE_BITS_DEF
) (
    input  logic [gcmc_pkg::CODE_W-1:0] code,
    output logic [gcmc_pkg::CODE_W-1:0] bin
);
    import gcmc_pkg::*;

    logic [CODE_W-1:0] masked;

    // Bits above CODE_BITS are dropped; each binary bit is the parity of the
    // Gray bits from its own position upwards.
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            masked[i] = (i < CODE_BITS) ? code[i] : 1'b0;
        end
        for (int i = 0; i < CODE_W; i++)
        begin
            bin[i] = ^(masked >> i);
        end
    end

endmodule

// File: hw/rtl/gcmc_pass_ctl.sv
module gcmc_pass_ctl #(
    parameter int SENSORS = gcmc_pkg::SENSORS_DEF,
    parameter int PASSES  = gcmc_pkg::PASSES_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 fire,
    input  logic [gcmc_pkg::CMD_W-1:0]                           cmd,
    input  logic [gcmc_pkg::MAX_SENSORS-1:0][gcmc_pkg::CODE_W-1:0] dec,
    output gcmc_pkg::res_t                                       res
);
    import gcmc_pkg::*;

    localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(PASSES);

    logic [PASS_W-1:0]              x_pass_reg, x_pass_next;
    logic [PASS_W-1:0]              y_pass_reg, y_pass_next;
    logic [SENSORS-1:0][CODE_W-1:0] x_last_reg;
    logic [SENSORS-1:0][CODE_W-1:0] y_last_reg;

    logic                           cmd_ok;
    logic                           sel_y;
    logic [PASS_W-1:0]              pass_cur;
    logic                           axis_full;
    logic                           same;
    logic [PASS_W-1:0]              pass_new;
    logic                           update;

    // The previous pass row is always the data of the last accepted report,
    // so one row per axis is kept instead of the whole pass table.
    always_comb
    begin
        cmd_ok    = (cmd == CMD_X) || (cmd == CMD_Y);
        sel_y     = (cmd == CMD_Y);
        pass_cur  = sel_y ? y_pass_reg : x_pass_reg;
        axis_full = (pass_cur >= PASS_LIMIT);
        same      = 1'b1;
        if (pass_cur != '0)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                if ((sel_y ? y_last_reg[i] : x_last_reg[i]) != dec[i])
                begin
                    same = 1'b0;
                end
            end
        end
        pass_new = same ? (pass_cur + PASS_W'(1)) : '0;
        update   = fire && cmd_ok && !axis_full;
    end

    always_comb
    begin
        x_pass_next = x_pass_reg;
        y_pass_next = y_pass_reg;
        if (update && !sel_y)
        begin
            x_pass_next = pass_new;
        end
        if (update && sel_y)
        begin
            y_pass_next = pass_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pass_reg <= '0;
            y_pass_reg <= '0;
        end
        else
        begin
            x_pass_reg <= x_pass_next;
            y_pass_reg <= y_pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && same && !sel_y)
        begin
            x_last_reg <= dec[SENSORS-1:0];
        end
        if (update && same && sel_y)
        begin
            y_last_reg <= dec[SENSORS-1:0];
        end
    end

    always_comb
    begin
        res.axis = cmd;
        if (!cmd_ok)
        begin
            res.status     = ST_INVALID;
            res.pass_count = '0;
            res.axis_done  = 1'b0;
            res.coord      = '0;
        end
        else if (axis_full)
        begin
            res.status     = ST_DONE;
            res.pass_count = pass_cur;
            res.axis_done  = 1'b1;
            res.coord      = dec;
        end
        else
        begin
            res.status     = same ? ST_ACCEPT : ST_RESTART;
            res.pass_count = pass_new;
            res.axis_done  = (pass_new >= PASS_LIMIT);
            res.coord      = dec;
        end
    end

endmodule

// File: hw/rtl/gray_coord_multipass_checker.sv
// Gray-coded coordinate checker with per-axis multipass consistency tracking.
// The input register holds each beat until its result is registered in the output
// register, which takes a new result whenever it is empty or m_tready drains it.
// Throughput: one report per cycle unless m_tready stalls the output;
// an input register and a result register surround a single stage of decode and compare logic.
// Reset (rst_n low, asynchronous) clears both pass counters and all valid flags.
`include "gray_coord_multipass_checker_macros.svh"

module gray_coord_multipass_checker #(
    parameter int SENSORS   = gcmc_pkg::SENSORS_DEF,
    parameter int PASSES    = gcmc_pkg::PASSES_DEF,
    parameter int CODE_BITS = gcmc_pkg::CODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // gray_code_0, gray_code_1, gray_code_2, gray_code_3
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pass_count, axis_done, coord_0..coord_3, zero pad
    output logic [3:0]  m_tuser    // status, axis_out
);
    import gcmc_pkg::*;

    logic                               in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]                   cmd_reg;
    logic [MAX_SENSORS-1:0][CODE_W-1:0] code_reg;
    logic                               out_valid_reg, out_valid_next;
    res_t                               res_reg;

    logic                               in_fire;
    logic                               advance;
    logic [MAX_SENSORS-1:0][CODE_W-1:0] dec;
    res_t                               res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_tuser;
            code_reg <= s_tdata;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    for (genvar g = 0; g < MAX_SENSORS; g++)
    begin : g_lane
        if (g < SENSORS)
        begin : g_used
            gcmc_gray_dec #(
                .CODE_BITS (CODE_BITS)
            ) u_dec (
                .code (code_reg[g]),
                .bin  (dec[g])
            );
        end
        else
        begin : g_unused
            assign dec[g] = '0;
        end
    end

    gcmc_pass_ctl #(
        .SENSORS (SENSORS),
        .PASSES  (PASSES)
    ) u_pass_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (cmd_reg),
        .dec   (dec),
        .res   (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {res_reg.axis, res_reg.status};
    assign m_tdata  = {5'b0, res_reg.coord, res_reg.axis_done, res_reg.pass_count};

    `GCMC_ASSERT_IMP(a_done_full, clk, rst_n,
        m_tvalid && res_reg.status == ST_DONE,
        res_reg.axis_done && res_reg.pass_count == PASS_W'(PASSES),
        "complete axis beat without full pass count")
    `GCMC_ASSERT_IMP(a_invalid_zero, clk, rst_n,
        m_tvalid && res_reg.status == ST_INVALID,
        res_reg.pass_count == '0 && !res_reg.axis_done && res_reg.coord == '0,
        "invalid command beat carries data")
    `GCMC_ASSERT_IMP(a_restart_zero, clk, rst_n,
        m_tvalid && res_reg.status == ST_RESTART,
        res_reg.pass_count == '0 && !res_reg.axis_done,
        "restart beat with non-zero pass count")
    `GCMC_ASSERT_NXT(a_advance_out, clk, rst_n, advance, out_valid_reg,
        "result lost on transfer to output register")

endmodule
